[hdl/dhoat_pkg.sv]
// package for the double hash open address table
// states, status codes, register indexes; no dependencies
package dhoat_pkg;
	localparam int TABLE_SIZE = 16;
	localparam int CFG_W = 16;
	localparam int STATUS_W = 2;
	localparam int SLOT_OUT_W = 4;
	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;
	typedef enum logic [1:0] {
		REG_MULT = 2'd0,
		REG_OFFSET = 2'd1,
		REG_PRIME = 2'd2,
		REG_STEP = 2'd3
	} reg_idx_t;
	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV1,
		S_DIV2,
		S_PROBE,
		S_READ,
		S_OUT
	} state_t;
	typedef struct packed {
		logic start;
		logic busy;
	} div_ctl_t;
endpackage

[hdl/dhoat_div.sv]
// sequential restoring divider, one quotient bit per cycle, remainder only
// uses dhoat_pkg
module dhoat_div #(
	parameter int NUM_W = 47
) (
	input logic clk,
	input logic arst_n,
	input dhoat_pkg::div_ctl_t ctl,
	input logic [NUM_W-1:0] num,
	input logic [dhoat_pkg::CFG_W-1:0] den,
	output logic done,
	output logic [dhoat_pkg::CFG_W-1:0] rem
);
	localparam int CW = $clog2(NUM_W + 1);
	logic [NUM_W-1:0] num_q;
	logic [dhoat_pkg::CFG_W:0] rem_q;
	logic [CW-1:0] cnt_q;
	logic run_q;
	logic [dhoat_pkg::CFG_W+1:0] trial;
	assign trial = {rem_q, num_q[NUM_W-1]} - {2'b00, den};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (ctl.start) begin
			run_q <= 1'b1;
			cnt_q <= CW'(NUM_W);
		end else if (run_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) run_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			num_q <= num;
			rem_q <= '0;
		end else if (run_q) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			if (!trial[dhoat_pkg::CFG_W+1]) rem_q <= trial[dhoat_pkg::CFG_W:0];
			else rem_q <= {rem_q[dhoat_pkg::CFG_W-1:0], num_q[NUM_W-1]};
		end
	end
	assign done = ctl.busy && !run_q && !ctl.start;
	assign rem = rem_q[dhoat_pkg::CFG_W-1:0];
endmodule

[hdl/double_hash_open_address_table.sv]
// double hashing open address table, top level
// sequence: two divisions, then one probe state per insert probe, a probe and a read
//   state per occupied search probe and a probe state for a free one, then the result
// items: one at a time, paced by the shared bit-serial divider and the single key store
//   read port
// reset: valid bits clear and config registers take their defaults at once, no clearing pass
// depends on dhoat_pkg and dhoat_div
module double_hash_open_address_table #(
	parameter int KEY_WIDTH = 31
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [15:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input logic command,
	input logic [KEY_WIDTH-1:0] key,
	output logic out_valid,
	input logic out_ready,
	output logic [1:0] status,
	output logic [3:0] slot
);
	localparam int TABLE_SIZE = dhoat_pkg::TABLE_SIZE;
	localparam int AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
	localparam int NW = KEY_WIDTH + dhoat_pkg::CFG_W;
	localparam int CW = $clog2(TABLE_SIZE + 1);

	// configuration registers
	logic [15:0] mult_q, offs_q, prime_q, stepm_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mult_q <= 16'd4;
			offs_q <= 16'd3;
			prime_q <= 16'd11;
			stepm_q <= 16'd1857;
		end else if (cfg_we) begin
			case (dhoat_pkg::reg_idx_t'(cfg_index))
				dhoat_pkg::REG_MULT: mult_q <= cfg_data;
				dhoat_pkg::REG_OFFSET: offs_q <= cfg_data;
				dhoat_pkg::REG_PRIME: prime_q <= cfg_data;
				dhoat_pkg::REG_STEP: stepm_q <= cfg_data;
				default: ;
			endcase
		end
	end

	dhoat_pkg::state_t state_q, state_d;
	logic cmd_q;
	logic [KEY_WIDTH-1:0] key_q;
	logic [NW-1:0] prod_q;
	logic [AW-1:0] base_q, step_q, pos_q;
	logic [CW-1:0] cnt_q;
	logic [TABLE_SIZE-1:0] valid_q;
	logic [KEY_WIDTH-1:0] mem [TABLE_SIZE];
	logic [KEY_WIDTH-1:0] rd_q;
	logic [1:0] status_q;
	logic [AW-1:0] slot_q;

	// shared divider: a*k+b mod p, then k mod m
	dhoat_pkg::div_ctl_t dctl;
	logic [NW-1:0] dnum;
	logic [15:0] dden, drem;
	logic ddone;
	logic dstart_q;
	assign dctl.start = dstart_q;
	assign dctl.busy = (state_q == dhoat_pkg::S_DIV1) || (state_q == dhoat_pkg::S_DIV2);
	assign dnum = (state_q == dhoat_pkg::S_DIV1) ? prod_q : NW'(key_q);
	assign dden = (state_q == dhoat_pkg::S_DIV1) ? prime_q : stepm_q;
	dhoat_div #(.NUM_W(NW)) u_div (
		.clk(clk), .arst_n(arst_n), .ctl(dctl), .num(dnum), .den(dden),
		.done(ddone), .rem(drem)
	);

	logic acc, probe_free, probe_hit, last;
	assign acc = in_valid && in_ready;
	assign probe_free = !valid_q[pos_q];
	assign probe_hit = rd_q == key_q;
	assign last = cnt_q == CW'(TABLE_SIZE - 1);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			dhoat_pkg::S_IDLE: if (acc) state_d = dhoat_pkg::S_DIV1;
			dhoat_pkg::S_DIV1: if (ddone) state_d = dhoat_pkg::S_DIV2;
			dhoat_pkg::S_DIV2: if (ddone) state_d = dhoat_pkg::S_PROBE;
			dhoat_pkg::S_PROBE: begin
				if (probe_free || cmd_q == 1'b0) begin
					if (probe_free || last) state_d = dhoat_pkg::S_OUT;
				end else state_d = dhoat_pkg::S_READ;
			end
			dhoat_pkg::S_READ: if (probe_hit || last) state_d = dhoat_pkg::S_OUT;
				else state_d = dhoat_pkg::S_PROBE;
			dhoat_pkg::S_OUT: if (out_ready) state_d = dhoat_pkg::S_IDLE;
			default: state_d = dhoat_pkg::S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready = state_q == dhoat_pkg::S_IDLE;
		out_valid = state_q == dhoat_pkg::S_OUT;
		status = status_q;
		slot = 4'(slot_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dhoat_pkg::S_IDLE;
			valid_q <= '0;
			dstart_q <= 1'b0;
		end else begin
			state_q <= state_d;
			dstart_q <= acc || (state_q == dhoat_pkg::S_DIV1 && ddone);
			if (state_q == dhoat_pkg::S_PROBE && probe_free && cmd_q == 1'b0)
				valid_q[pos_q] <= 1'b1;
		end
	end

	// key store: one write port and one registered read port
	always_ff @(posedge clk) begin
		if (state_q == dhoat_pkg::S_PROBE && probe_free && cmd_q == 1'b0)
			mem[pos_q] <= key_q;
		rd_q <= mem[pos_q];
	end

	// datapath
	logic [AW-1:0] nxt_pos;
	assign nxt_pos = AW'((AW+1)'(pos_q) + (AW+1)'(step_q));
	always_ff @(posedge clk) begin
		if (acc) begin
			cmd_q <= command;
			key_q <= key;
			prod_q <= NW'(key) * NW'(mult_q) + NW'(offs_q);
		end
		if (state_q == dhoat_pkg::S_DIV1 && ddone)
			base_q <= (prime_q == '0) ? '0 : AW'(drem);
		if (state_q == dhoat_pkg::S_DIV2 && ddone) begin
			step_q <= (stepm_q == '0) ? '0 : AW'(drem);
			pos_q <= base_q;
			cnt_q <= '0;
			status_q <= cmd_q ? dhoat_pkg::ST_NOT_FOUND : dhoat_pkg::ST_OVERFLOW;
			slot_q <= '0;
		end
		if (state_q == dhoat_pkg::S_PROBE) begin
			if (probe_free && cmd_q == 1'b0) begin
				status_q <= dhoat_pkg::ST_DONE;
				slot_q <= pos_q;
			end else if (!probe_free && cmd_q == 1'b0) begin
				pos_q <= nxt_pos;
				cnt_q <= cnt_q + 1'b1;
			end
		end
		if (state_q == dhoat_pkg::S_READ) begin
			if (probe_hit) begin
				status_q <= dhoat_pkg::ST_DONE;
				slot_q <= pos_q;
			end else begin
				pos_q <= nxt_pos;
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid) else $error("ready while result pending");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status))
		else $error("result dropped");
	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != dhoat_pkg::ST_DONE |-> slot == 4'd0)
		else $error("slot nonzero on miss");
endmodule

[tb/tb.sv]
// testbench for double_hash_open_address_table: random and directed inserts and searches
// keeps its own table model and checks every result; depends on dhoat_pkg and the rtl
`timescale 1ns / 100ps

module tb;
	localparam int SLOTS = dhoat_pkg::TABLE_SIZE;
	localparam int KW = 31;
	localparam int CYCLE_LIMIT = 2000000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [15:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic command;
	logic [KW-1:0] key;
	logic out_valid;
	logic out_ready;
	logic [1:0] status;
	logic [3:0] slot;

	double_hash_open_address_table #(
		.KEY_WIDTH(KW)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.key(key),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.slot(slot)
	);

	// model copy of the table and its registers
	logic [15:0] mdl_mult, mdl_offset, mdl_prime, mdl_step;
	logic [KW-1:0] mdl_keys [SLOTS];
	logic mdl_valid [SLOTS];

	typedef struct packed {
		logic [1:0] st;
		logic [3:0] sl;
	} lookup_result_t;

	lookup_result_t pending_results[$];
	int errors;
	int cycles;
	bit stall_long;   // receiver holds off while set
	bit burst_idle;   // sender gaps disabled while clear

	// --------------------------------------------------------------
	// clock and cycle limit
	// --------------------------------------------------------------
	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	task automatic report(input string what);
		$display("mismatch: %s", what);
		errors++;
	endtask

	// --------------------------------------------------------------
	// predictor: one probe walk per item, updates the model table
	// --------------------------------------------------------------
	function automatic lookup_result_t probe_table(input logic cmd, input logic [KW-1:0] k);
		lookup_result_t r;
		logic [63:0] base, stp, j;
		// the full product fits easily in 64 bits
		base = (mdl_prime == 0) ? 64'd0
			: (64'(mdl_mult) * 64'(k) + 64'(mdl_offset)) % 64'(mdl_prime);
		stp = (mdl_step == 0) ? 64'd0 : 64'(k) % 64'(mdl_step);
		r.st = (cmd == 1'b0) ? dhoat_pkg::ST_OVERFLOW : dhoat_pkg::ST_NOT_FOUND;
		r.sl = '0;
		for (int i = 0; i < SLOTS; i++) begin
			j = (base + 64'(i) * stp) % SLOTS;
			if (cmd == 1'b0) begin
				if (!mdl_valid[j]) begin
					mdl_valid[j] = 1'b1;
					mdl_keys[j] = k;
					r.st = dhoat_pkg::ST_DONE;
					r.sl = j[3:0];
					break;
				end
			end else begin
				if (!mdl_valid[j])
					break;
				if (mdl_keys[j] == k) begin
					r.st = dhoat_pkg::ST_DONE;
					r.sl = j[3:0];
					break;
				end
			end
		end
		return r;
	endfunction

	// --------------------------------------------------------------
	// receiver: random stall pattern, plus long hold-off on request
	// --------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (stall_long)
				out_ready <= 1'b0;
			else if (cycles % 97 < 20)
				out_ready <= 1'b1; // stretch with no stalls
			else
				out_ready <= ($urandom_range(0, 3) != 0);
		end
	end

	// result checker
	always @(posedge clk) begin
		lookup_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report("result with nothing expected");
			end else begin
				want = pending_results.pop_front();
				if (status !== want.st)
					report($sformatf("status %0d want %0d", status, want.st));
				if (slot !== want.sl)
					report($sformatf("slot %0d want %0d", slot, want.sl));
			end
		end
	end

	// --------------------------------------------------------------
	// sender: one item, random gaps only while burst_idle keeps them enabled
	// --------------------------------------------------------------
	task automatic send_item(input logic cmd, input logic [KW-1:0] k);
		// valid was dropped at the last accept, so move past that edge first
		if (burst_idle && $urandom_range(0, 7) == 0)
			repeat ($urandom_range(1, 30)) @(posedge clk);
		else
			@(posedge clk);
		in_valid <= 1'b1;
		command <= cmd;
		key <= k;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pending_results.push_back(probe_table(cmd, k));
		in_valid <= 1'b0;
	endtask

	task automatic drain;
		while (pending_results.size() != 0) @(posedge clk);
		// block may still be finishing its own state update
		repeat (300) @(posedge clk);
	endtask

	task automatic write_reg(input dhoat_pkg::reg_idx_t idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			dhoat_pkg::REG_MULT: mdl_mult = val;
			dhoat_pkg::REG_OFFSET: mdl_offset = val;
			dhoat_pkg::REG_PRIME: mdl_prime = val;
			dhoat_pkg::REG_STEP: mdl_step = val;
			default: ;
		endcase
	endtask

	function automatic logic [KW-1:0] rand_key;
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return KW'($urandom_range(0, 40));
			default: return KW'($urandom);
		endcase
	endfunction

	// --------------------------------------------------------------
	// tests
	// --------------------------------------------------------------
	task automatic test_directed;
		logic [KW-1:0] k;
		send_item(1'b1, '0);          // search of an empty table
		send_item(1'b0, '0);
		send_item(1'b0, '0);          // duplicate key
		send_item(1'b1, '0);
		send_item(1'b0, '1);          // widest key
		send_item(1'b1, '1);
		send_item(1'b1, KW'(12345));
		drain();
		// zero prime and zero step: every probe hits one slot
		write_reg(dhoat_pkg::REG_PRIME, 16'd0);
		write_reg(dhoat_pkg::REG_STEP, 16'd0);
		send_item(1'b0, KW'(77));
		send_item(1'b0, KW'(78));     // overflow unless slot 0 is free
		send_item(1'b1, KW'(78));
		drain();
		// maximum multiplier, offset and prime, step modulus one; more inserts than the table has slots
		write_reg(dhoat_pkg::REG_MULT, 16'hffff);
		write_reg(dhoat_pkg::REG_OFFSET, 16'hffff);
		write_reg(dhoat_pkg::REG_PRIME, 16'hffff);
		write_reg(dhoat_pkg::REG_STEP, 16'd1);
		for (int i = 0; i < 18; i++) begin
			k = rand_key();
			send_item(1'b0, k);
		end
		send_item(1'b1, KW'(5));
		drain();
	endtask

	task automatic test_random_phase(input int n);
		logic [KW-1:0] recent[$];
		logic [KW-1:0] k;
		logic cmd;
		for (int i = 0; i < n; i++) begin
			cmd = 1'($urandom_range(0, 1));
			// searches mostly use keys that were inserted
			if (cmd && recent.size() != 0 && $urandom_range(0, 3) != 0)
				k = recent[$urandom_range(0, recent.size() - 1)];
			else
				k = rand_key();
			if (!cmd) recent.push_back(k);
			if (recent.size() > 32) void'(recent.pop_front());
			send_item(cmd, k);
		end
	endtask

	task automatic test_config_sweep;
		for (int p = 0; p < 6; p++) begin
			drain();
			write_reg(dhoat_pkg::REG_MULT, (p == 0) ? 16'd0 : 16'($urandom));
			write_reg(dhoat_pkg::REG_OFFSET, (p == 1) ? 16'd0 : 16'($urandom));
			write_reg(dhoat_pkg::REG_PRIME,
				(p == 2) ? 16'd2 : 16'($urandom_range(2, 65535)));
			write_reg(dhoat_pkg::REG_STEP,
				(p == 3) ? 16'hffff : 16'($urandom_range(0, 40)));
			test_random_phase(200);
		end
	endtask

	task automatic test_backpressure;
		// receiver holds off while the sender keeps offering
		fork
			begin
				stall_long = 1'b1;
				repeat (2000) @(posedge clk);
				stall_long = 1'b0;
			end
			test_random_phase(20);
		join
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = dhoat_pkg::REG_MULT;
		cfg_data = '0;
		in_valid = 1'b0;
		command = 1'b0;
		key = '0;
		stall_long = 1'b0;
		burst_idle = 1'b1;
		mdl_mult = 16'd4;
		mdl_offset = 16'd3;
		mdl_prime = 16'd11;
		mdl_step = 16'd1857;
		for (int i = 0; i < SLOTS; i++) begin
			mdl_valid[i] = 1'b0;
			mdl_keys[i] = '0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_backpressure();
		burst_idle = 1'b0;
		test_random_phase(100);   // back to back
		burst_idle = 1'b1;
		test_config_sweep();
		test_random_phase(100);
		drain();

		if (errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end
endmodule
